// File: src/pdcb_pkg.sv
// Package for the pair distance class binner: widths, codes and the structs
// passed between the datapath, the histogram stage and the top level.
// No dependencies.
`default_nettype none

package pdcb_pkg;

    // Sizing
    localparam int MAX_BREAKS = 16;
    localparam int COORD_BITS = 24;
    localparam int COUNT_BITS = 32;

    // Fixed field widths
    localparam int KIND_BITS      = 2;
    localparam int BLOCK_BITS     = 16;
    localparam int SLOT_BITS      = 4;
    localparam int BREAK_BITS     = 25;
    localparam int NB_BITS        = 5;
    localparam int CLASS_BITS     = 4;
    localparam int SQ_OUT_BITS    = 51;
    localparam int COUNT_OUT_BITS = 32;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 25;

    // Derived widths
    localparam int IDX_BITS = (MAX_BREAKS > 1) ? $clog2(MAX_BREAKS) : 1;
    localparam int CNT_BITS = $clog2(MAX_BREAKS + 1);
    localparam int DSQ_BITS = 2 * COORD_BITS + 1;
    localparam int BSQ_BITS = 2 * BREAK_BITS;
    localparam int CMP_BITS = (DSQ_BITS > BSQ_BITS) ? DSQ_BITS : BSQ_BITS;

    // Register reset values
    localparam logic [NB_BITS-1:0]    BREAKS_IN_USE_RESET = NB_BITS'(16);
    localparam logic [BREAK_BITS-1:0] MAX_DISTANCE_RESET  = {BREAK_BITS{1'b1}};
    localparam logic [BSQ_BITS-1:0]   MAX_SQ_RESET =
        BSQ_BITS'(MAX_DISTANCE_RESET) * BSQ_BITS'(MAX_DISTANCE_RESET);

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_BREAKS_IN_USE = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_DISTANCE  = CFG_INDEX_BITS'(1);

    // Item kinds
    typedef enum logic [KIND_BITS-1:0] {
        KIND_CLASSIFY    = 2'd0,
        KIND_WRITE_BREAK = 2'd1,
        KIND_READ_COUNTS = 2'd2,
        KIND_CLEAR       = 2'd3
    } kind_t;

    // One input transaction
    typedef struct packed {
        kind_t                         kind;
        logic signed [COORD_BITS-1:0]  x_a;
        logic signed [COORD_BITS-1:0]  y_a;
        logic [BLOCK_BITS-1:0]         block_a;
        logic signed [COORD_BITS-1:0]  x_b;
        logic signed [COORD_BITS-1:0]  y_b;
        logic [BLOCK_BITS-1:0]         block_b;
        logic [SLOT_BITS-1:0]          slot;
        logic [BREAK_BITS-1:0]         break_value;
    } pair_item_t;

    // Configuration seen by the datapath
    typedef struct packed {
        logic [NB_BITS-1:0]  breaks_in_use;
        logic [BSQ_BITS-1:0] max_sq;
    } bin_cfg_t;

    // Classified item handed to the histogram stage
    typedef struct packed {
        kind_t                 kind;
        logic [SLOT_BITS-1:0]  slot;
        logic                  class_valid;
        logic [IDX_BITS-1:0]   cls;
        logic                  same_block;
        logic [DSQ_BITS-1:0]   dsq;
    } class_item_t;

    // One result transaction
    typedef struct packed {
        logic                      class_valid;
        logic [CLASS_BITS-1:0]     distance_class;
        logic [SQ_OUT_BITS-1:0]    squared_distance;
        logic                      same_block;
        logic [COUNT_OUT_BITS-1:0] count_all;
        logic [COUNT_OUT_BITS-1:0] count_same_block;
        logic [COUNT_OUT_BITS-1:0] count_across;
    } result_t;

endpackage

`default_nettype wire

// File: src/pdcb_ifs.sv
// Channel interfaces of the pair distance class binner: pair input, result
// output and configuration write. Depends on pdcb_pkg.
`default_nettype none

interface pdcb_pair_if import pdcb_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic [KIND_BITS-1:0]         kind;
    logic signed [COORD_BITS-1:0] x_a;
    logic signed [COORD_BITS-1:0] y_a;
    logic [BLOCK_BITS-1:0]        block_a;
    logic signed [COORD_BITS-1:0] x_b;
    logic signed [COORD_BITS-1:0] y_b;
    logic [BLOCK_BITS-1:0]        block_b;
    logic [SLOT_BITS-1:0]         slot;
    logic [BREAK_BITS-1:0]        break_value;

    modport source (
        output valid, kind, x_a, y_a, block_a, x_b, y_b, block_b, slot, break_value,
        input  ready
    );
    modport sink (
        input  valid, kind, x_a, y_a, block_a, x_b, y_b, block_b, slot, break_value,
        output ready
    );
endinterface

interface pdcb_result_if import pdcb_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      class_valid;
    logic [CLASS_BITS-1:0]     distance_class;
    logic [SQ_OUT_BITS-1:0]    squared_distance;
    logic                      same_block;
    logic [COUNT_OUT_BITS-1:0] count_all;
    logic [COUNT_OUT_BITS-1:0] count_same_block;
    logic [COUNT_OUT_BITS-1:0] count_across;

    modport source (
        output valid, class_valid, distance_class, squared_distance, same_block,
               count_all, count_same_block, count_across,
        input  ready
    );
    modport sink (
        input  valid, class_valid, distance_class, squared_distance, same_block,
               count_all, count_same_block, count_across,
        output ready
    );
endinterface

interface pdcb_cfg_if import pdcb_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: src/pdcb_dist.sv
// Distance datapath: input register, abs differences, squares, sum, parallel
// compares against the squared break table, and class selection.
// Depends on pdcb_pkg.
`default_nettype none

module pdcb_dist import pdcb_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  pair_item_t  pair_item,
    input  logic        pair_valid,
    output logic        pair_ready,
    input  bin_cfg_t    bin_cfg,
    output class_item_t cls_item,
    output logic        cls_valid,
    input  logic        cls_ready
);

    localparam int NSTAGES = 6;

    // Stage control
    logic [NSTAGES-1:0] v_reg;
    logic [NSTAGES-1:0] adv;

    // Stage 0: input register
    pair_item_t s0_item_reg;

    // Stage 1: absolute differences
    kind_t                 s1_kind_reg;
    logic [SLOT_BITS-1:0]  s1_slot_reg;
    logic [COORD_BITS-1:0] s1_dx_reg;
    logic [COORD_BITS-1:0] s1_dy_reg;
    logic                  s1_same_reg;
    logic [BREAK_BITS-1:0] s1_break_reg;

    // Stage 2: squares
    kind_t                   s2_kind_reg;
    logic [SLOT_BITS-1:0]    s2_slot_reg;
    logic [2*COORD_BITS-1:0] s2_dx2_reg;
    logic [2*COORD_BITS-1:0] s2_dy2_reg;
    logic                    s2_same_reg;
    logic [BSQ_BITS-1:0]     s2_bsq_reg;

    // Stage 3: squared distance
    kind_t                s3_kind_reg;
    logic [SLOT_BITS-1:0] s3_slot_reg;
    logic [DSQ_BITS-1:0]  s3_dsq_reg;
    logic                 s3_same_reg;

    // Stage 4: compare results
    kind_t                 s4_kind_reg;
    logic [SLOT_BITS-1:0]  s4_slot_reg;
    logic [DSQ_BITS-1:0]   s4_dsq_reg;
    logic                  s4_same_reg;
    logic [MAX_BREAKS-1:0] s4_hit_reg;
    logic                  s4_below_reg;

    // Stage 5: classified item
    class_item_t s5_item_reg;

    // Squared break table, undefined until written
    logic [BSQ_BITS-1:0] break_sq_reg [MAX_BREAKS];

    // Combinational stage values
    logic signed [COORD_BITS:0] dx_s;
    logic signed [COORD_BITS:0] dy_s;
    logic [COORD_BITS-1:0]      dx_abs;
    logic [COORD_BITS-1:0]      dy_abs;
    logic [MAX_BREAKS-1:0]      hit;
    logic                       below_max;
    logic [CNT_BITS-1:0]        hit_cnt;
    logic [CNT_BITS-1:0]        nb_eff;
    logic [CNT_BITS-1:0]        cls_full;
    logic                       in_class;
    logic                       s2_slot_ok;
    class_item_t                s5_next;

    // Per-stage advance: a stage loads when empty or when the next one moves
    always_comb
    begin
        adv[NSTAGES-1] = !v_reg[NSTAGES-1] || cls_ready;
        for (int k = NSTAGES - 2; k >= 0; k--)
        begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
    end

    assign pair_ready = adv[0];
    assign cls_valid  = v_reg[NSTAGES-1];
    assign cls_item   = s5_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                v_reg[0] <= pair_valid;
            end
            for (int k = 1; k < NSTAGES; k++)
            begin
                if (adv[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // Stage 1 logic: signed differences folded to magnitudes
    always_comb
    begin
        dx_s   = (COORD_BITS+1)'(s0_item_reg.x_a) - (COORD_BITS+1)'(s0_item_reg.x_b);
        dy_s   = (COORD_BITS+1)'(s0_item_reg.y_a) - (COORD_BITS+1)'(s0_item_reg.y_b);
        dx_abs = dx_s[COORD_BITS] ? COORD_BITS'(-dx_s) : COORD_BITS'(dx_s);
        dy_abs = dy_s[COORD_BITS] ? COORD_BITS'(-dy_s) : COORD_BITS'(dy_s);
    end

    // Stage 4 logic: one compare per break lane, lanes past breaks_in_use off
    always_comb
    begin
        for (int i = 0; i < MAX_BREAKS; i++)
        begin
            hit[i] = (int'(bin_cfg.breaks_in_use) > i)
                && (CMP_BITS'(break_sq_reg[i]) <= CMP_BITS'(s3_dsq_reg));
        end
        below_max = CMP_BITS'(s3_dsq_reg) < CMP_BITS'(bin_cfg.max_sq);
    end

    // Stage 5 logic: class = breaks passed minus one, inside 0..B-2
    always_comb
    begin
        hit_cnt = CNT_BITS'($countones(s4_hit_reg));
        if (int'(bin_cfg.breaks_in_use) > MAX_BREAKS)
        begin
            nb_eff = CNT_BITS'(MAX_BREAKS);
        end
        else
        begin
            nb_eff = CNT_BITS'(bin_cfg.breaks_in_use);
        end
        cls_full = hit_cnt - CNT_BITS'(1);
        in_class = (s4_kind_reg == KIND_CLASSIFY) && s4_below_reg
            && (hit_cnt != '0) && (hit_cnt < nb_eff);

        s5_next.kind        = s4_kind_reg;
        s5_next.slot        = s4_slot_reg;
        s5_next.class_valid = in_class;
        s5_next.cls         = in_class ? cls_full[IDX_BITS-1:0] : '0;
        s5_next.same_block  = s4_same_reg;
        s5_next.dsq         = s4_dsq_reg;
    end

    // Stage payload registers
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s0_item_reg <= pair_item;
        end
        if (adv[1])
        begin
            s1_kind_reg  <= s0_item_reg.kind;
            s1_slot_reg  <= s0_item_reg.slot;
            s1_dx_reg    <= dx_abs;
            s1_dy_reg    <= dy_abs;
            s1_same_reg  <= (s0_item_reg.block_a == s0_item_reg.block_b);
            s1_break_reg <= s0_item_reg.break_value;
        end
        if (adv[2])
        begin
            s2_kind_reg <= s1_kind_reg;
            s2_slot_reg <= s1_slot_reg;
            s2_dx2_reg  <= (2*COORD_BITS)'(s1_dx_reg) * (2*COORD_BITS)'(s1_dx_reg);
            s2_dy2_reg  <= (2*COORD_BITS)'(s1_dy_reg) * (2*COORD_BITS)'(s1_dy_reg);
            s2_same_reg <= s1_same_reg;
            s2_bsq_reg  <= BSQ_BITS'(s1_break_reg) * BSQ_BITS'(s1_break_reg);
        end
        if (adv[3])
        begin
            s3_kind_reg <= s2_kind_reg;
            s3_slot_reg <= s2_slot_reg;
            s3_dsq_reg  <= DSQ_BITS'(s2_dx2_reg) + DSQ_BITS'(s2_dy2_reg);
            s3_same_reg <= s2_same_reg;
        end
        if (adv[4])
        begin
            s4_kind_reg  <= s3_kind_reg;
            s4_slot_reg  <= s3_slot_reg;
            s4_dsq_reg   <= s3_dsq_reg;
            s4_same_reg  <= s3_same_reg;
            s4_hit_reg   <= hit;
            s4_below_reg <= below_max;
        end
        if (adv[5])
        begin
            s5_item_reg <= s5_next;
        end
    end

    // Break write leaves stage 2; later pairs reach the compare after it
    assign s2_slot_ok = int'(s2_slot_reg) < MAX_BREAKS;

    always_ff @(posedge clk)
    begin
        if (v_reg[2] && adv[3] && (s2_kind_reg == KIND_WRITE_BREAK) && s2_slot_ok)
        begin
            break_sq_reg[IDX_BITS'(s2_slot_reg)] <= s2_bsq_reg;
        end
    end

endmodule

`default_nettype wire

// File: src/pdcb_hist.sv
// Histogram stage: three saturating per-class counter tables with one
// read-modify-write per transaction, plus the result register.
// Depends on pdcb_pkg.
`default_nettype none

module pdcb_hist import pdcb_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  class_item_t cls_item,
    input  logic        cls_valid,
    output logic        cls_ready,
    output result_t     result,
    output logic        result_valid,
    input  logic        result_ready
);

    logic [COUNT_BITS-1:0] count_all_reg    [MAX_BREAKS];
    logic [COUNT_BITS-1:0] count_same_reg   [MAX_BREAKS];
    logic [COUNT_BITS-1:0] count_across_reg [MAX_BREAKS];
    logic                  res_valid_reg;
    result_t               result_reg;

    logic                  adv;
    logic                  fire;
    logic                  slot_ok;
    logic [IDX_BITS-1:0]   addr;
    logic [COUNT_BITS-1:0] rd_all;
    logic [COUNT_BITS-1:0] rd_same;
    logic [COUNT_BITS-1:0] rd_across;
    result_t               result_next;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        return (c == '1) ? c : c + COUNT_BITS'(1);
    endfunction

    // Output register parts this stage from the receiver
    assign adv          = !res_valid_reg || result_ready;
    assign cls_ready    = adv;
    assign fire         = cls_valid && adv;
    assign result_valid = res_valid_reg;
    assign result       = result_reg;

    // Single table address: the class for pairs, the slot for reads
    always_comb
    begin
        slot_ok   = int'(cls_item.slot) < MAX_BREAKS;
        addr      = (cls_item.kind == KIND_CLASSIFY) ? cls_item.cls
                                                     : IDX_BITS'(cls_item.slot);
        rd_all    = count_all_reg[addr];
        rd_same   = count_same_reg[addr];
        rd_across = count_across_reg[addr];
    end

    // Result fields; those a kind does not produce stay zero
    always_comb
    begin
        result_next = '0;
        case (cls_item.kind)
            KIND_CLASSIFY:
            begin
                result_next.class_valid      = cls_item.class_valid;
                result_next.distance_class   = CLASS_BITS'(cls_item.cls);
                result_next.squared_distance = SQ_OUT_BITS'(cls_item.dsq);
                result_next.same_block       = cls_item.same_block;
            end
            KIND_READ_COUNTS:
            begin
                if (slot_ok)
                begin
                    result_next.count_all        = COUNT_OUT_BITS'(rd_all);
                    result_next.count_same_block = COUNT_OUT_BITS'(rd_same);
                    result_next.count_across     = COUNT_OUT_BITS'(rd_across);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Counter tables and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_BREAKS; i++)
            begin
                count_all_reg[i]    <= '0;
                count_same_reg[i]   <= '0;
                count_across_reg[i] <= '0;
            end
        end
        else
        begin
            if (adv)
            begin
                res_valid_reg <= cls_valid;
            end
            if (fire)
            begin
                case (cls_item.kind)
                    KIND_CLASSIFY:
                    begin
                        if (cls_item.class_valid)
                        begin
                            count_all_reg[addr] <= sat_inc(rd_all);
                            if (cls_item.same_block)
                            begin
                                count_same_reg[addr] <= sat_inc(rd_same);
                            end
                            else
                            begin
                                count_across_reg[addr] <= sat_inc(rd_across);
                            end
                        end
                    end
                    KIND_CLEAR:
                    begin
                        for (int i = 0; i < MAX_BREAKS; i++)
                        begin
                            count_all_reg[i]    <= '0;
                            count_same_reg[i]   <= '0;
                            count_across_reg[i] <= '0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

endmodule

`default_nettype wire

// File: src/pair_distance_class_binner.sv
// Pair distance class binner: top level with configuration registers.
// Depends on pdcb_pkg, pdcb_ifs, pdcb_dist and pdcb_hist.
//
// Usage:
//   pairs   - input channel, one transaction per item: classify a pair,
//             write a break value, read the three counters of a class, or
//             clear the counters. Every item gives exactly one result.
//   results - output channel carrying class, squared distance, same-block
//             flag and the counters of a read class.
//   cfg     - register write channel, always ready; index 0 breaks_in_use,
//             index 1 max_distance. Write only while the block is idle.
// Path: a pairs transaction passes the input register, five more datapath
// registers and the result register before its result is presented.
// Throughput: one item per cycle while results.ready is high; break compares
// run in parallel and counters update by read-modify-write in the histogram stage.
// Reset: counters zero, breaks_in_use 16, max_distance 2^25-1; break values
// are undefined until written and must be written before use.
// Stall: when results.ready is low the pipeline keeps accepting until all
// seven stages hold a transaction, then pairs.ready drops.
`default_nettype none

module pair_distance_class_binner import pdcb_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    pdcb_pair_if.sink     pairs,
    pdcb_result_if.source results,
    pdcb_cfg_if.sink      cfg
);

    logic [NB_BITS-1:0]    breaks_in_use_reg;
    logic [BREAK_BITS-1:0] max_distance_reg;
    logic [BSQ_BITS-1:0]   max_sq_reg;

    pair_item_t  pair_item;
    bin_cfg_t    bin_cfg;
    class_item_t cls_item;
    logic        cls_valid;
    logic        cls_ready;
    result_t     result;
    logic        result_valid;

    // Configuration registers; max distance squared follows max_distance_reg in the next cycle
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            breaks_in_use_reg <= BREAKS_IN_USE_RESET;
            max_distance_reg  <= MAX_DISTANCE_RESET;
            max_sq_reg        <= MAX_SQ_RESET;
        end
        else
        begin
            max_sq_reg <= BSQ_BITS'(max_distance_reg) * BSQ_BITS'(max_distance_reg);
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_BREAKS_IN_USE: breaks_in_use_reg <= NB_BITS'(cfg.data);
                    REG_MAX_DISTANCE:  max_distance_reg  <= BREAK_BITS'(cfg.data);
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign bin_cfg.breaks_in_use = breaks_in_use_reg;
    assign bin_cfg.max_sq        = max_sq_reg;

    // Input transaction
    always_comb
    begin
        pair_item.kind        = kind_t'(pairs.kind);
        pair_item.x_a         = pairs.x_a;
        pair_item.y_a         = pairs.y_a;
        pair_item.block_a     = pairs.block_a;
        pair_item.x_b         = pairs.x_b;
        pair_item.y_b         = pairs.y_b;
        pair_item.block_b     = pairs.block_b;
        pair_item.slot        = pairs.slot;
        pair_item.break_value = pairs.break_value;
    end

    pdcb_dist u_dist (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair_item  (pair_item),
        .pair_valid (pairs.valid),
        .pair_ready (pairs.ready),
        .bin_cfg    (bin_cfg),
        .cls_item   (cls_item),
        .cls_valid  (cls_valid),
        .cls_ready  (cls_ready)
    );

    pdcb_hist u_hist (
        .clk          (clk),
        .rst_n        (rst_n),
        .cls_item     (cls_item),
        .cls_valid    (cls_valid),
        .cls_ready    (cls_ready),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (results.ready)
    );

    // Output transaction
    assign results.valid            = result_valid;
    assign results.class_valid      = result.class_valid;
    assign results.distance_class   = result.distance_class;
    assign results.squared_distance = result.squared_distance;
    assign results.same_block       = result.same_block;
    assign results.count_all        = result.count_all;
    assign results.count_same_block = result.count_same_block;
    assign results.count_across     = result.count_across;

    // Input backpressure only when the whole pipeline is full and stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        !pairs.ready |-> (results.valid && !results.ready))
        else $error("pairs stalled while the result side is not blocked");

    // An unclassified result carries class zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.class_valid) |-> (results.distance_class == '0))
        else $error("nonzero class on an unclassified result");

    // A classified pair never carries counter values
    assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.class_valid) |->
            (results.count_all == '0 && results.count_same_block == '0
             && results.count_across == '0))
        else $error("counter fields set on a classified pair result");

endmodule

`default_nettype wire

// File: tb/sv/tb_pair_distance_class_binner.sv
`timescale 1ns / 1ps
// Self-checking testbench for pair_distance_class_binner: random bursty pair traffic,
// a stalling result sink and a scoreboard fed by an in-bench histogram predictor.
// Depends on pdcb_pkg, pdcb_ifs and the binner RTL.

module tb_pair_distance_class_binner;
    import pdcb_pkg::*;

    localparam int     DRAIN_CYCLES = 16;
    localparam longint CYCLE_LIMIT  = 500000;
    localparam int     PHASES       = 8;
    localparam int     PHASE_ITEMS  = 230;
    localparam int     MAX_REPORTS  = 40;
    localparam int     COORD_MAX    = 8388607;
    localparam int     COORD_MIN    = -8388608;
    localparam int     BREAK_TOP    = 33554431;
    localparam int     BREAK_STEP   = 2097152;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PATTERN,
        STALL_LONG
    } stall_mode_t;

    typedef struct packed {
        logic [CFG_INDEX_BITS-1:0] index;
        logic [CFG_DATA_BITS-1:0]  data;
    } reg_write_t;

    logic clk;
    logic rst_n;

    pdcb_pair_if   pairs_if();
    pdcb_result_if results_if();
    pdcb_cfg_if    cfg_if();

    pair_distance_class_binner u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .pairs   (pairs_if),
        .results (results_if),
        .cfg     (cfg_if)
    );

    // Stimulus and scoreboard storage
    pair_item_t pair_drv;
    pair_item_t pending_pairs[$];
    result_t    bin_outcomes[$];
    reg_write_t reg_writes[$];
    int         reg_writes_issued;
    int         reg_writes_done;
    int         burst_left;
    int         gap_left;
    int         mismatches;
    int         results_seen;
    longint     cycle_count;
    result_t    want;

    // Result sink stall pattern
    stall_mode_t stall_mode;
    int          mode_left;
    int          hold_left;
    logic [15:0] stall_pattern;

    // Predictor state: squared breaks, histograms and register copies
    logic [63:0]               break_sq [MAX_BREAKS];
    logic [COUNT_OUT_BITS-1:0] hist_all [MAX_BREAKS];
    logic [COUNT_OUT_BITS-1:0] hist_same [MAX_BREAKS];
    logic [COUNT_OUT_BITS-1:0] hist_across [MAX_BREAKS];
    logic [NB_BITS-1:0]        nb_reg;
    logic [63:0]               maxd_reg;

    assign pairs_if.kind        = pair_drv.kind;
    assign pairs_if.x_a         = pair_drv.x_a;
    assign pairs_if.y_a         = pair_drv.y_a;
    assign pairs_if.block_a     = pair_drv.block_a;
    assign pairs_if.x_b         = pair_drv.x_b;
    assign pairs_if.y_b         = pair_drv.y_b;
    assign pairs_if.block_b     = pair_drv.block_b;
    assign pairs_if.slot        = pair_drv.slot;
    assign pairs_if.break_value = pair_drv.break_value;

    // Classify, load a break, read or clear; returns the one result of the item
    function automatic result_t bin_pair_item(input pair_item_t it);
        result_t     r;
        longint      a;
        longint      b;
        logic [63:0] dx;
        logic [63:0] dy;
        logic [63:0] dsq;
        logic [63:0] maxsq;
        int          nb;
        int          hits;
        int          cls;
        logic        hit;
        r = '0;
        case (it.kind)
            KIND_CLASSIFY:
            begin
                a = $signed(it.x_a);
                b = $signed(it.x_b);
                dx = (a >= b) ? a - b : b - a;
                a = $signed(it.y_a);
                b = $signed(it.y_b);
                dy = (a >= b) ? a - b : b - a;
                dsq = dx * dx + dy * dy;
                maxsq = maxd_reg * maxd_reg;
                nb = (nb_reg > MAX_BREAKS) ? MAX_BREAKS : int'(nb_reg);
                hits = 0;
                for (int i = 0; i < MAX_BREAKS; i++)
                    if (i < nb && break_sq[i] <= dsq)
                        hits++;
                hit = (dsq < maxsq) && (hits >= 1) && (hits + 1 <= nb);
                cls = hit ? hits - 1 : 0;
                if (hit)
                begin
                    if (hist_all[cls] != '1)
                        hist_all[cls]++;
                    if (it.block_a == it.block_b)
                    begin
                        if (hist_same[cls] != '1)
                            hist_same[cls]++;
                    end
                    else if (hist_across[cls] != '1)
                        hist_across[cls]++;
                end
                r.class_valid = hit;
                r.distance_class = CLASS_BITS'(cls);
                r.squared_distance = dsq[SQ_OUT_BITS-1:0];
                r.same_block = (it.block_a == it.block_b);
            end
            KIND_WRITE_BREAK:
                break_sq[it.slot] = 64'(it.break_value) * 64'(it.break_value);
            KIND_READ_COUNTS:
            begin
                r.count_all = hist_all[it.slot];
                r.count_same_block = hist_same[it.slot];
                r.count_across = hist_across[it.slot];
            end
            default:
            begin
                for (int i = 0; i < MAX_BREAKS; i++)
                begin
                    hist_all[i] = '0;
                    hist_same[i] = '0;
                    hist_across[i] = '0;
                end
            end
        endcase
        return r;
    endfunction

    // Item with every field random but kind, preset to KIND_CLEAR; callers overwrite what matters
    function automatic pair_item_t noise_item();
        pair_item_t it;
        it.kind = KIND_CLEAR;
        it.x_a = COORD_BITS'($urandom);
        it.y_a = COORD_BITS'($urandom);
        it.block_a = BLOCK_BITS'($urandom);
        it.x_b = COORD_BITS'($urandom);
        it.y_b = COORD_BITS'($urandom);
        it.block_b = BLOCK_BITS'($urandom);
        it.slot = SLOT_BITS'($urandom);
        it.break_value = BREAK_BITS'($urandom);
        return it;
    endfunction

    function automatic pair_item_t op_item(input kind_t k, input int slot, input int bv);
        pair_item_t it;
        it = noise_item();
        it.kind = k;
        it.slot = SLOT_BITS'(slot);
        it.break_value = BREAK_BITS'(bv);
        return it;
    endfunction

    function automatic pair_item_t pair_at(input int xa, input int ya, input int ba,
                                           input int xb, input int yb, input int bb);
        pair_item_t it;
        it = noise_item();
        it.kind = KIND_CLASSIFY;
        it.x_a = COORD_BITS'(xa);
        it.y_a = COORD_BITS'(ya);
        it.block_a = BLOCK_BITS'(ba);
        it.x_b = COORD_BITS'(xb);
        it.y_b = COORD_BITS'(yb);
        it.block_b = BLOCK_BITS'(bb);
        return it;
    endfunction

    function automatic logic signed [COORD_BITS-1:0] clamp_coord(input int v);
        if (v > COORD_MAX)
            return COORD_BITS'(COORD_MAX);
        if (v < COORD_MIN)
            return COORD_BITS'(COORD_MIN);
        return COORD_BITS'(v);
    endfunction

    // Pair whose distance mostly falls around the current break range
    function automatic pair_item_t rand_pair(input int unsigned span);
        pair_item_t it;
        int         lim;
        int         ox;
        int         oy;
        it = noise_item();
        it.kind = KIND_CLASSIFY;
        if ($urandom_range(0, 1) == 0)
            it.block_b = it.block_a;
        if ($urandom_range(0, 7) == 0)
            return it;
        lim = int'(span >> $urandom_range(0, 6));
        ox = $urandom_range(0, lim);
        oy = $urandom_range(0, lim);
        if ($urandom_range(0, 9) == 0)
        begin
            ox = 0;
            oy = 0;
        end
        if ($urandom_range(0, 1) == 0)
            ox = -ox;
        if ($urandom_range(0, 1) == 0)
            oy = -oy;
        it.x_b = clamp_coord(int'($signed(it.x_a)) + ox);
        it.y_b = clamp_coord(int'($signed(it.y_a)) + oy);
        return it;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at result %0d: %s got 0x%0h, want 0x%0h",
                     results_seen, what, got, exp_val);
    endtask

    task automatic queue_reg_write(input logic [CFG_INDEX_BITS-1:0] idx, input int value);
        reg_write_t w;
        w.index = idx;
        w.data = CFG_DATA_BITS'(value);
        reg_writes.push_back(w);
        reg_writes_issued++;
        while (reg_writes_done != reg_writes_issued)
            @(posedge clk);
    endtask

    // Block is idle once every sent item has produced its result; checked
    // mid-cycle so that driver and monitor updates have settled
    task automatic wait_idle();
        @(negedge clk);
        while (pending_pairs.size() != 0 || pairs_if.valid || bin_outcomes.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Pair driver: bursts of random length separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pairs_if.valid <= 1'b0;
            pair_drv <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (pairs_if.valid && pairs_if.ready)
                bin_outcomes.push_back(bin_pair_item(pair_drv));
            if (!pairs_if.valid || pairs_if.ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    pairs_if.valid <= 1'b0;
                end
                else if (pending_pairs.size() != 0)
                begin
                    pair_drv <= pending_pairs.pop_front();
                    pairs_if.valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    pairs_if.valid <= 1'b0;
            end
        end
    end

    // Register write driver; predictor copies follow each accepted write
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_if.valid <= 1'b0;
            cfg_if.index <= REG_BREAKS_IN_USE;
            cfg_if.data <= '0;
            reg_writes_done <= 0;
        end
        else
        begin
            if (cfg_if.valid && cfg_if.ready)
            begin
                if (cfg_if.index == REG_BREAKS_IN_USE)
                    nb_reg = cfg_if.data[NB_BITS-1:0];
                else if (cfg_if.index == REG_MAX_DISTANCE)
                    maxd_reg = 64'(cfg_if.data[BREAK_BITS-1:0]);
                reg_writes_done <= reg_writes_done + 1;
            end
            if (!cfg_if.valid || cfg_if.ready)
            begin
                if (reg_writes.size() != 0)
                begin
                    cfg_if.index <= reg_writes[0].index;
                    cfg_if.data <= reg_writes[0].data;
                    void'(reg_writes.pop_front());
                    cfg_if.valid <= 1'b1;
                end
                else
                    cfg_if.valid <= 1'b0;
            end
        end
    end

    // Result sink: stall behavior changes to a random mode whenever its mode counter runs out
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            results_if.ready <= 1'b1;
            stall_mode <= STALL_NONE;
            mode_left <= 100;
            hold_left <= 0;
            stall_pattern <= 16'hC3A5;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode <= stall_mode_t'($urandom_range(0, 3));
                mode_left <= $urandom_range(32, 256);
            end
            else
                mode_left <= mode_left - 1;
            stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
            case (stall_mode)
                STALL_NONE:
                    results_if.ready <= 1'b1;
                STALL_RANDOM:
                    results_if.ready <= ($urandom_range(0, 3) != 0);
                STALL_PATTERN:
                    results_if.ready <= stall_pattern[15];
                default:
                begin
                    if (hold_left != 0)
                    begin
                        hold_left <= hold_left - 1;
                        results_if.ready <= 1'b0;
                    end
                    else
                    begin
                        results_if.ready <= 1'b1;
                        if ($urandom_range(0, 15) == 0)
                            hold_left <= $urandom_range(1, 24);
                    end
                end
            endcase
        end
    end

    // Result monitor: compare each transaction against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && results_if.valid && results_if.ready)
        begin
            if (bin_outcomes.size() == 0)
                report_mismatch("result with nothing pending", 0, 0);
            else
            begin
                want = bin_outcomes.pop_front();
                if (results_if.class_valid !== want.class_valid)
                    report_mismatch("class_valid", results_if.class_valid, want.class_valid);
                if (results_if.distance_class !== want.distance_class)
                    report_mismatch("distance_class", results_if.distance_class,
                                    want.distance_class);
                if (results_if.squared_distance !== want.squared_distance)
                    report_mismatch("squared_distance", results_if.squared_distance,
                                    want.squared_distance);
                if (results_if.same_block !== want.same_block)
                    report_mismatch("same_block", results_if.same_block, want.same_block);
                if (results_if.count_all !== want.count_all)
                    report_mismatch("count_all", results_if.count_all, want.count_all);
                if (results_if.count_same_block !== want.count_same_block)
                    report_mismatch("count_same_block", results_if.count_same_block,
                                    want.count_same_block);
                if (results_if.count_across !== want.count_across)
                    report_mismatch("count_across", results_if.count_across,
                                    want.count_across);
            end
            results_seen++;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[pair_distance_class_binner] ERROR");
            $finish;
        end
    end

    // Stimulus sequence
    initial
    begin
        int unsigned top;
        int unsigned step;
        int          nb_sel;
        int          maxd_sel;
        int unsigned pick;
        rst_n = 1'b0;
        cycle_count = 0;
        mismatches = 0;
        results_seen = 0;
        reg_writes_issued = 0;
        nb_reg = NB_BITS'(16);
        maxd_reg = 64'(BREAK_TOP);
        for (int i = 0; i < MAX_BREAKS; i++)
        begin
            break_sq[i] = '0;
            hist_all[i] = '0;
            hist_same[i] = '0;
            hist_across[i] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty counters, evenly spaced breaks, edge distances
        pending_pairs.push_back(op_item(KIND_READ_COUNTS, 0, 0));
        for (int i = 0; i < MAX_BREAKS - 1; i++)
            pending_pairs.push_back(op_item(KIND_WRITE_BREAK, i, i * BREAK_STEP));
        pending_pairs.push_back(op_item(KIND_WRITE_BREAK, MAX_BREAKS - 1, BREAK_TOP));
        // widest span, same block
        pending_pairs.push_back(pair_at(COORD_MAX, COORD_MAX, 65535,
                                        COORD_MIN, COORD_MIN, 65535));
        // zero distance lands in class zero when the first break is zero
        pending_pairs.push_back(pair_at(1234, -5678, 0, 1234, -5678, 65535));
        // distance exactly on a break
        pending_pairs.push_back(pair_at(-3 * BREAK_STEP / 2, 7, 9,
                                        3 * BREAK_STEP / 2, 7, 10));
        // raise the first break, then fall just below it
        pending_pairs.push_back(op_item(KIND_WRITE_BREAK, 0, 1000));
        pending_pairs.push_back(pair_at(0, 0, 3, 999, 0, 3));
        pending_pairs.push_back(op_item(KIND_READ_COUNTS, 11, 0));
        pending_pairs.push_back(op_item(KIND_READ_COUNTS, 3, 0));
        pending_pairs.push_back(op_item(KIND_CLEAR, 0, 0));
        pending_pairs.push_back(op_item(KIND_READ_COUNTS, 3, 0));

        // Random phases, each under its own register setting
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: begin nb_sel = 16; maxd_sel = BREAK_TOP; end
                1: begin nb_sel = 2;  maxd_sel = 4000000;   end
                2: begin nb_sel = 0;  maxd_sel = BREAK_TOP; end
                3: begin nb_sel = 1;  maxd_sel = BREAK_TOP; end
                4: begin nb_sel = 31; maxd_sel = 20000000;  end
                5: begin nb_sel = 8;  maxd_sel = 0;         end
                6: begin nb_sel = 17; maxd_sel = 1;         end
                default:
                begin
                    nb_sel = $urandom_range(2, 16);
                    maxd_sel = $urandom_range(0, BREAK_TOP);
                end
            endcase
            wait_idle();
            queue_reg_write(REG_BREAKS_IN_USE, nb_sel);
            queue_reg_write(REG_MAX_DISTANCE, maxd_sel);

            // fresh ascending break set scaled to this phase
            top = (p == 0) ? BREAK_TOP : $urandom_range(4096, BREAK_TOP);
            step = top / MAX_BREAKS;
            for (int i = 0; i < MAX_BREAKS; i++)
                pending_pairs.push_back(op_item(KIND_WRITE_BREAK, i,
                                                i * step + $urandom_range(0, step - 1)));
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 68)
                    pending_pairs.push_back(rand_pair(top));
                else if (pick < 80)
                    // mostly in range, sometimes anywhere so breaks go unsorted
                    pending_pairs.push_back(op_item(KIND_WRITE_BREAK, $urandom_range(0, 15),
                        ($urandom_range(0, 1) == 0) ? $urandom_range(0, top)
                                                    : $urandom_range(0, BREAK_TOP)));
                else if (pick < 97)
                    pending_pairs.push_back(op_item(KIND_READ_COUNTS, $urandom_range(0, 15),
                                                    $urandom));
                else
                    pending_pairs.push_back(op_item(KIND_CLEAR, $urandom_range(0, 15),
                                                    $urandom));
            end
        end

        wait_idle();
        if (mismatches == 0)
            $display("[pair_distance_class_binner] OK");
        else
            $display("[pair_distance_class_binner] ERROR");
        $finish;
    end

endmodule
